// ===== rtl/epi_pkg.sv =====
// Shared widths, codes and the sequencer program of the eased position interpolator.
package epi_pkg;

    // Field and datapath widths.
    localparam int POS_W     = 32;
    localparam int TIME_W    = 24;
    localparam int DT_W      = 16;
    localparam int FRAC_BITS = 16;
    localparam int T_W       = FRAC_BITS + 1;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int MUL_W     = FRAC_BITS + 2;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int DIFF_W    = POS_W + 1;
    localparam int CNT_W     = $clog2(FRAC_BITS);
    localparam int AXIS_W    = 2;
    localparam int PC_W      = 5;

    localparam logic [T_W-1:0] ONE = T_W'(1) << FRAC_BITS;
    localparam logic [MUL_W-1:0] THREE_ONE = MUL_W'(3) << FRAC_BITS;
    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(2);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(FRAC_BITS - 1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X  = 3'd0,
        CFG_START_Y  = 3'd1,
        CFG_START_Z  = 3'd2,
        CFG_GOAL_X   = 3'd3,
        CFG_GOAL_Y   = 3'd4,
        CFG_GOAL_Z   = 3'd5,
        CFG_DURATION = 3'd6,
        CFG_EASING   = 3'd7
    } t_cfg_idx;

    // Easing mode codes.
    localparam logic [MODE_W-1:0] EASE_LINEAR  = 2'd0;
    localparam logic [MODE_W-1:0] EASE_SMOOTH  = 2'd1;
    localparam logic [MODE_W-1:0] EASE_OUT_QUAD = 2'd2;
    localparam logic [MODE_W-1:0] EASE_LINEAR_ALT = 2'd3;

    // Datapath operations selected by the control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_TLOAD,
        OP_SM_SQ,
        OP_SM_S,
        OP_SM_MUL,
        OP_SM_E,
        OP_EO_MUL,
        OP_EO_E,
        OP_LR_DIFF,
        OP_LR_MLO,
        OP_LR_MHI,
        OP_LR_SUM,
        OP_OUT
    } t_op;

    // Jump conditions.
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_IN,
        COND_DUR_ZERO,
        COND_DIV_MORE,
        COND_LINEAR,
        COND_EASEOUT,
        COND_AXIS_MORE,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    // Program addresses.
    localparam logic [PC_W-1:0] P_ACCEPT   = 5'd0;
    localparam logic [PC_W-1:0] P_DIV_INIT = 5'd1;
    localparam logic [PC_W-1:0] P_DIV      = 5'd2;
    localparam logic [PC_W-1:0] P_TLOAD    = 5'd3;
    localparam logic [PC_W-1:0] P_MODE     = 5'd4;
    localparam logic [PC_W-1:0] P_SM_SQ    = 5'd5;
    localparam logic [PC_W-1:0] P_SM_S     = 5'd6;
    localparam logic [PC_W-1:0] P_SM_MUL   = 5'd7;
    localparam logic [PC_W-1:0] P_SM_E     = 5'd8;
    localparam logic [PC_W-1:0] P_EO_MUL   = 5'd9;
    localparam logic [PC_W-1:0] P_EO_E     = 5'd10;
    localparam logic [PC_W-1:0] P_LR_DIFF  = 5'd11;
    localparam logic [PC_W-1:0] P_LR_MLO   = 5'd12;
    localparam logic [PC_W-1:0] P_LR_MHI   = 5'd13;
    localparam logic [PC_W-1:0] P_LR_SUM   = 5'd14;
    localparam logic [PC_W-1:0] P_OUT      = 5'd15;
    localparam logic [PC_W-1:0] P_RET      = 5'd16;

    // Microcode ROM: a jump is taken when its condition holds, else the step advances.
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, target: P_ACCEPT};
        case (pc)
            P_ACCEPT:   w = '{op: OP_ACCEPT,   cond: COND_NO_IN,     target: P_ACCEPT};
            P_DIV_INIT: w = '{op: OP_DIV_INIT, cond: COND_DUR_ZERO,  target: P_OUT};
            P_DIV:      w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE,  target: P_DIV};
            P_TLOAD:    w = '{op: OP_TLOAD,    cond: COND_LINEAR,    target: P_LR_DIFF};
            P_MODE:     w = '{op: OP_NOP,      cond: COND_EASEOUT,   target: P_EO_MUL};
            P_SM_SQ:    w = '{op: OP_SM_SQ,    cond: COND_NEVER,     target: P_ACCEPT};
            P_SM_S:     w = '{op: OP_SM_S,     cond: COND_NEVER,     target: P_ACCEPT};
            P_SM_MUL:   w = '{op: OP_SM_MUL,   cond: COND_NEVER,     target: P_ACCEPT};
            P_SM_E:     w = '{op: OP_SM_E,     cond: COND_ALWAYS,    target: P_LR_DIFF};
            P_EO_MUL:   w = '{op: OP_EO_MUL,   cond: COND_NEVER,     target: P_ACCEPT};
            P_EO_E:     w = '{op: OP_EO_E,     cond: COND_NEVER,     target: P_ACCEPT};
            P_LR_DIFF:  w = '{op: OP_LR_DIFF,  cond: COND_NEVER,     target: P_ACCEPT};
            P_LR_MLO:   w = '{op: OP_LR_MLO,   cond: COND_NEVER,     target: P_ACCEPT};
            P_LR_MHI:   w = '{op: OP_LR_MHI,   cond: COND_NEVER,     target: P_ACCEPT};
            P_LR_SUM:   w = '{op: OP_LR_SUM,   cond: COND_AXIS_MORE, target: P_LR_DIFF};
            P_OUT:      w = '{op: OP_OUT,      cond: COND_OUT_BUSY,  target: P_OUT};
            P_RET:      w = '{op: OP_NOP,      cond: COND_ALWAYS,    target: P_ACCEPT};
            default:    w = '{op: OP_NOP,      cond: COND_ALWAYS,    target: P_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/epi_if.sv =====
// Valid/ready channel interfaces for tick beats in and position beats out.
interface epi_in_if;
    logic                          valid;
    logic                          ready;
    logic [epi_pkg::DT_W-1:0]      delta_time;
    logic                          restart;

    modport source (output valid, output delta_time, output restart, input ready);
    modport sink   (input valid, input delta_time, input restart, output ready);
endinterface

interface epi_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [epi_pkg::POS_W-1:0]  pos_x;
    logic signed [epi_pkg::POS_W-1:0]  pos_y;
    logic signed [epi_pkg::POS_W-1:0]  pos_z;
    logic [epi_pkg::T_W-1:0]           progress;
    logic                              reached;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output progress, output reached, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input progress, input reached, output ready);
endinterface

// ===== rtl/eased_position_interpolator.sv =====
// Eased 3-D position interpolator: a microcoded sequencer over one shared multiplier.
//
// One tick beat is taken at a time; the next is accepted only after the last has passed
// the output step. The sequencer program runs a 16-step restoring divider that forms
// progress one bit a cycle; the curved eases add three or five steps on one shared
// 18x18 multiplier, and each of the three axes takes four steps, two of them multiplies.
// A tick with zero duration goes from the divider setup straight to the output step.
// A stalled consumer holds one finished beat while the next one is worked; the
// sequencer waits at its output step while that beat is still held.
// Configuration is to be written only while the block is idle: the user is bound to
// this, and the block itself does not enforce it. There is no clearing pass.
module eased_position_interpolator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [epi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [epi_pkg::POS_W-1:0]      i_cfg_data,
    epi_in_if.sink                         i_in,
    epi_out_if.source                      o_out
);

    // Configuration registers.
    logic [epi_pkg::POS_W-1:0]  r_start [3];
    logic [epi_pkg::POS_W-1:0]  r_goal [3];
    logic [epi_pkg::TIME_W-1:0] r_duration;
    logic [epi_pkg::MODE_W-1:0] r_mode;

    // Sequencer and datapath state.
    logic [epi_pkg::PC_W-1:0]   r_pc;
    logic [epi_pkg::PC_W-1:0]   n_pc;
    logic [epi_pkg::TIME_W-1:0] r_elapsed;
    logic [epi_pkg::TIME_W-1:0] r_rem;
    logic [epi_pkg::T_W-1:0]    r_quot;
    logic [epi_pkg::CNT_W-1:0]  r_cnt;
    logic [epi_pkg::T_W-1:0]    r_t;
    logic [epi_pkg::T_W-1:0]    r_e;
    logic [epi_pkg::PROD_W-1:0] r_prod;
    logic [epi_pkg::POS_W-1:0]  r_acc;
    logic                       r_sticky;
    logic                       r_neg;
    logic [epi_pkg::DIFF_W-1:0] r_mag;
    logic [epi_pkg::AXIS_W-1:0] r_axis;
    logic [epi_pkg::POS_W-1:0]  r_pos [3];

    // Output register.
    logic                       r_out_valid;
    logic [epi_pkg::POS_W-1:0]  r_out_pos [3];
    logic [epi_pkg::T_W-1:0]    r_out_progress;
    logic                       r_out_reached;

    epi_pkg::t_uword            uw;
    logic                       in_acc;
    logic                       out_busy;
    logic                       dur_zero;
    logic                       jump;
    logic [epi_pkg::TIME_W-1:0] base;
    logic [epi_pkg::TIME_W:0]   sum;
    logic [epi_pkg::TIME_W:0]   rem2;
    logic                       ge;
    logic [epi_pkg::T_W-1:0]    u_val;
    logic [epi_pkg::MUL_W-1:0]  mul_a;
    logic [epi_pkg::MUL_W-1:0]  mul_b;
    logic [epi_pkg::DIFF_W-1:0] diff;
    logic [epi_pkg::POS_W-1:0]  q_sum;
    logic [epi_pkg::POS_W-1:0]  offset;

    // Control word fetch and handshake terms.
    assign uw       = epi_pkg::ucode(r_pc);
    assign i_in.ready = (uw.op == epi_pkg::OP_ACCEPT);
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_busy = r_out_valid && !o_out.ready;
    assign dur_zero = (r_duration == '0);

    // Jump condition select and next step.
    always_comb begin
        case (uw.cond)
            epi_pkg::COND_NEVER:     jump = 1'b0;
            epi_pkg::COND_ALWAYS:    jump = 1'b1;
            epi_pkg::COND_NO_IN:     jump = !i_in.valid;
            epi_pkg::COND_DUR_ZERO:  jump = dur_zero;
            epi_pkg::COND_DIV_MORE:  jump = (r_cnt != '0);
            epi_pkg::COND_LINEAR:    jump = (r_mode == epi_pkg::EASE_LINEAR) ||
                                            (r_mode == epi_pkg::EASE_LINEAR_ALT);
            epi_pkg::COND_EASEOUT:   jump = (r_mode == epi_pkg::EASE_OUT_QUAD);
            epi_pkg::COND_AXIS_MORE: jump = (r_axis != epi_pkg::LAST_AXIS);
            epi_pkg::COND_OUT_BUSY:  jump = out_busy;
            default:                 jump = 1'b1;
        endcase
        n_pc = jump ? uw.target : r_pc + epi_pkg::PC_W'(1);
    end

    // Elapsed time update and one restoring divide step.
    always_comb begin
        base = i_in.restart ? '0 : r_elapsed;
        sum  = {1'b0, base} + (epi_pkg::TIME_W + 1)'(i_in.delta_time);
        rem2 = {r_rem, 1'b0};
        ge   = (rem2 >= {1'b0, r_duration});
    end

    // Shared multiplier operand select.
    always_comb begin
        u_val = epi_pkg::ONE - r_t;
        mul_a = '0;
        mul_b = '0;
        case (uw.op)
            epi_pkg::OP_SM_SQ: begin
                mul_a = epi_pkg::MUL_W'(r_t);
                mul_b = epi_pkg::MUL_W'(r_t);
            end
            epi_pkg::OP_SM_MUL: begin
                mul_a = epi_pkg::MUL_W'(r_e);
                mul_b = epi_pkg::THREE_ONE - {r_t, 1'b0};
            end
            epi_pkg::OP_EO_MUL: begin
                mul_a = epi_pkg::MUL_W'(u_val);
                mul_b = epi_pkg::MUL_W'(u_val);
            end
            epi_pkg::OP_LR_MLO: begin
                mul_a = epi_pkg::MUL_W'(r_mag[epi_pkg::FRAC_BITS-1:0]);
                mul_b = epi_pkg::MUL_W'(r_e);
            end
            epi_pkg::OP_LR_MHI: begin
                mul_a = epi_pkg::MUL_W'(r_mag[epi_pkg::DIFF_W-1:epi_pkg::FRAC_BITS]);
                mul_b = epi_pkg::MUL_W'(r_e);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Axis difference one bit wider than a position, and final offset modulo the position width.
    always_comb begin
        diff   = {r_goal[r_axis][epi_pkg::POS_W-1], r_goal[r_axis]}
               - {r_start[r_axis][epi_pkg::POS_W-1], r_start[r_axis]};
        q_sum  = r_prod[epi_pkg::POS_W-1:0] + r_acc;
        offset = r_neg ? (epi_pkg::POS_W'(0) - (q_sum + epi_pkg::POS_W'(r_sticky))) : q_sum;
    end

    // Sequencer, datapath and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= epi_pkg::P_ACCEPT;
            r_out_valid <= 1'b0;
            r_elapsed   <= '0;
            r_duration  <= '0;
            r_mode      <= epi_pkg::EASE_LINEAR;
            for (int i = 0; i < 3; i++) begin
                r_start[i] <= '0;
                r_goal[i]  <= '0;
            end
        end else begin
            r_pc <= n_pc;

            // Result beat leaves when the sink takes it, unless the output step refills it.
            if (r_out_valid && o_out.ready && (uw.op != epi_pkg::OP_OUT)) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    epi_pkg::CFG_START_X:  r_start[0] <= i_cfg_data;
                    epi_pkg::CFG_START_Y:  r_start[1] <= i_cfg_data;
                    epi_pkg::CFG_START_Z:  r_start[2] <= i_cfg_data;
                    epi_pkg::CFG_GOAL_X:   r_goal[0]  <= i_cfg_data;
                    epi_pkg::CFG_GOAL_Y:   r_goal[1]  <= i_cfg_data;
                    epi_pkg::CFG_GOAL_Z:   r_goal[2]  <= i_cfg_data;
                    epi_pkg::CFG_DURATION: r_duration <= i_cfg_data[epi_pkg::TIME_W-1:0];
                    epi_pkg::CFG_EASING:   r_mode     <= i_cfg_data[epi_pkg::MODE_W-1:0];
                    default: ;
                endcase
            end

            case (uw.op)
                epi_pkg::OP_ACCEPT: begin
                    // Saturate elapsed at the duration; zero duration holds it unless restarted.
                    if (in_acc) begin
                        if (dur_zero) begin
                            r_elapsed <= base;
                        end else if (sum > {1'b0, r_duration}) begin
                            r_elapsed <= r_duration;
                        end else begin
                            r_elapsed <= sum[epi_pkg::TIME_W-1:0];
                        end
                    end
                end
                epi_pkg::OP_DIV_INIT: begin
                    // The integer bit of progress is set only when the move is complete.
                    r_quot <= epi_pkg::T_W'(r_elapsed >= r_duration);
                    r_rem  <= (r_elapsed >= r_duration) ? '0 : r_elapsed;
                    r_cnt  <= epi_pkg::DIV_LAST;
                end
                epi_pkg::OP_DIV_STEP: begin
                    r_rem  <= ge ? epi_pkg::TIME_W'(rem2 - {1'b0, r_duration})
                                 : rem2[epi_pkg::TIME_W-1:0];
                    r_quot <= {r_quot[epi_pkg::T_W-2:0], ge};
                    r_cnt  <= r_cnt - epi_pkg::CNT_W'(1);
                end
                epi_pkg::OP_TLOAD: begin
                    r_t    <= r_quot;
                    r_e    <= r_quot;
                    r_axis <= '0;
                end
                epi_pkg::OP_SM_SQ, epi_pkg::OP_SM_MUL, epi_pkg::OP_EO_MUL,
                epi_pkg::OP_LR_MLO: begin
                    r_prod <= mul_a * mul_b;
                end
                epi_pkg::OP_SM_S, epi_pkg::OP_SM_E: begin
                    r_e <= r_prod[epi_pkg::FRAC_BITS +: epi_pkg::T_W];
                end
                epi_pkg::OP_EO_E: begin
                    r_e <= epi_pkg::ONE - r_prod[epi_pkg::FRAC_BITS +: epi_pkg::T_W];
                end
                epi_pkg::OP_LR_DIFF: begin
                    r_neg <= diff[epi_pkg::DIFF_W-1];
                    r_mag <= diff[epi_pkg::DIFF_W-1] ? (epi_pkg::DIFF_W'(0) - diff) : diff;
                end
                epi_pkg::OP_LR_MHI: begin
                    // Keep the floored low partial product and its lost fraction.
                    r_acc    <= epi_pkg::POS_W'(r_prod >> epi_pkg::FRAC_BITS);
                    r_sticky <= |r_prod[epi_pkg::FRAC_BITS-1:0];
                    r_prod   <= mul_a * mul_b;
                end
                epi_pkg::OP_LR_SUM: begin
                    r_pos[r_axis] <= r_start[r_axis] + offset;
                    r_axis        <= r_axis + epi_pkg::AXIS_W'(1);
                end
                epi_pkg::OP_OUT: begin
                    if (!out_busy) begin
                        r_out_valid    <= 1'b1;
                        r_out_progress <= dur_zero ? epi_pkg::ONE : r_t;
                        r_out_reached  <= (r_elapsed >= r_duration);
                        for (int i = 0; i < 3; i++) begin
                            r_out_pos[i] <= dur_zero ? r_goal[i] : r_pos[i];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.pos_x    = r_out_pos[0];
    assign o_out.pos_y    = r_out_pos[1];
    assign o_out.pos_z    = r_out_pos[2];
    assign o_out.progress = r_out_progress;
    assign o_out.reached  = r_out_reached;

    // Elapsed time never passes a nonzero duration after a tick.
    a_elapsed_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !dur_zero) |=> (r_elapsed <= r_duration))
        else $error("elapsed time above duration");

    // The divider remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == epi_pkg::P_DIV) |-> (r_rem < r_duration))
        else $error("divider remainder out of range");

    // Progress on a result beat never exceeds one.
    a_progress_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.progress <= epi_pkg::ONE))
        else $error("progress above one");

endmodule

// ===== verif/eased_position_interpolator_test.sv =====
// Self-checking testbench for the eased position interpolator: tick beats in, position beats out.
`timescale 1ns / 1ps

module eased_position_interpolator_test;

    localparam int     HALF_PERIOD   = 10;
    localparam int     RESET_CYCLES  = 8;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     QUIET_LIMIT   = 4000;
    localparam int     RAND_PHASES   = 16;
    localparam int     PHASE_TICKS   = 71;
    localparam longint UNIT          = longint'(1) << epi_pkg::FRAC_BITS;
    localparam logic [7:0] ALL_REGS  = 8'hff;
    localparam logic [7:0] DUR_REG   = 8'h01 << epi_pkg::CFG_DURATION;
    localparam logic [epi_pkg::MODE_W-1:0] MODE_CYCLE [4] =
        '{epi_pkg::EASE_LINEAR, epi_pkg::EASE_SMOOTH, epi_pkg::EASE_OUT_QUAD,
          epi_pkg::EASE_LINEAR_ALT};

    typedef struct {
        logic signed [epi_pkg::POS_W-1:0] x;
        logic signed [epi_pkg::POS_W-1:0] y;
        logic signed [epi_pkg::POS_W-1:0] z;
        logic [epi_pkg::T_W-1:0]          progress;
        logic                             reached;
    } t_position;

    // Tracks the move state, predicts each position beat and checks the block against it.
    class t_position_scoreboard;
        logic [epi_pkg::POS_W-1:0]  start_pos [3];
        logic [epi_pkg::POS_W-1:0]  goal_pos [3];
        logic [epi_pkg::TIME_W-1:0] duration;
        logic [epi_pkg::MODE_W-1:0] easing;
        logic [epi_pkg::TIME_W-1:0] elapsed;
        t_position                  expected_q [$];
        int                         mismatches;
        int                         ticks_noted;
        int                         results_checked;

        function new();
            for (int k = 0; k < 3; k++) begin
                start_pos[k] = '0;
                goal_pos[k]  = '0;
            end
            duration        = '0;
            easing          = epi_pkg::EASE_LINEAR;
            elapsed         = '0;
            mismatches      = 0;
            ticks_noted     = 0;
            results_checked = 0;
        endfunction

        function void set_reg(epi_pkg::t_cfg_idx idx, logic [epi_pkg::POS_W-1:0] data);
            case (idx)
                epi_pkg::CFG_START_X:  start_pos[0] = data;
                epi_pkg::CFG_START_Y:  start_pos[1] = data;
                epi_pkg::CFG_START_Z:  start_pos[2] = data;
                epi_pkg::CFG_GOAL_X:   goal_pos[0] = data;
                epi_pkg::CFG_GOAL_Y:   goal_pos[1] = data;
                epi_pkg::CFG_GOAL_Z:   goal_pos[2] = data;
                epi_pkg::CFG_DURATION: duration = data[epi_pkg::TIME_W-1:0];
                epi_pkg::CFG_EASING:   easing = data[epi_pkg::MODE_W-1:0];
                default: ;
            endcase
        endfunction

        // Shapes the linear progress with the selected curve; codes other than two
        // curved ones fall back to linear.
        function longint eased(longint t);
            longint sq;
            longint rem;
            case (easing)
                epi_pkg::EASE_SMOOTH: begin
                    sq = (t * t) >>> epi_pkg::FRAC_BITS;
                    return (sq * (3 * UNIT - 2 * t)) >>> epi_pkg::FRAC_BITS;
                end
                epi_pkg::EASE_OUT_QUAD: begin
                    rem = UNIT - t;
                    return UNIT - ((rem * rem) >>> epi_pkg::FRAC_BITS);
                end
                default: return t;
            endcase
        endfunction

        // Start plus the floored share of the span; exact in 64 bits.
        function logic [epi_pkg::POS_W-1:0] lerp(logic [epi_pkg::POS_W-1:0] from,
                                                 logic [epi_pkg::POS_W-1:0] to,
                                                 longint e);
            longint base;
            longint span;
            base = longint'($signed(from));
            span = longint'($signed(to)) - base;
            return epi_pkg::POS_W'(base + ((span * e) >>> epi_pkg::FRAC_BITS));
        endfunction

        function void note_tick(logic [epi_pkg::DT_W-1:0] dt, logic restart);
            t_position               p;
            logic [epi_pkg::TIME_W:0] sum;
            longint                  t;
            longint                  e;
            ticks_noted++;
            if (restart)
                elapsed = '0;
            if (duration == '0) begin
                // No move set up: the goal comes straight back and time stands still.
                p.x        = goal_pos[0];
                p.y        = goal_pos[1];
                p.z        = goal_pos[2];
                p.progress = epi_pkg::ONE;
                p.reached  = 1'b1;
            end else begin
                sum = {1'b0, elapsed} + (epi_pkg::TIME_W + 1)'(dt);
                if (sum > {1'b0, duration})
                    sum = {1'b0, duration};
                elapsed    = sum[epi_pkg::TIME_W-1:0];
                t          = (longint'(elapsed) << epi_pkg::FRAC_BITS) / longint'(duration);
                e          = eased(t);
                p.x        = lerp(start_pos[0], goal_pos[0], e);
                p.y        = lerp(start_pos[1], goal_pos[1], e);
                p.z        = lerp(start_pos[2], goal_pos[2], e);
                p.progress = epi_pkg::T_W'(t);
                p.reached  = (elapsed >= duration);
            end
            expected_q.push_back(p);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_position got);
            t_position want;
            results_checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%0t: position beat with no tick pending, got x=%0d y=%0d z=%0d",
                         $time, got.x, got.y, got.z);
                return;
            end
            want = expected_q.pop_front();
            compare_field("pos_x", want.x, got.x);
            compare_field("pos_y", want.y, got.y);
            compare_field("pos_z", want.z, got.z);
            compare_field("progress", want.progress, got.progress);
            compare_field("reached", want.reached, got.reached);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [epi_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [epi_pkg::POS_W-1:0]     cfg_data;
    logic [epi_pkg::POS_W-1:0]     cfg_image [8];
    logic                          hold_go = 1'b0;
    int                            send_idle_pct = 0;
    int                            recv_stall_pct = 0;
    int                            settings_loaded = 0;
    int                            quiet_cycles = 0;
    t_position_scoreboard          sb;

    epi_in_if  in_ch ();
    epi_out_if out_ch ();

    eased_position_interpolator u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // Note accepted ticks and check accepted position beats, both sampled at the edge.
    always @(posedge clk) begin : beat_monitor
        t_position got;
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_tick(in_ch.delta_time, in_ch.restart);
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.x        = out_ch.pos_x;
            got.y        = out_ch.pos_y;
            got.z        = out_ch.pos_z;
            got.progress = out_ch.progress;
            got.reached  = out_ch.reached;
            sb.check_result(got);
        end
    end

    // End the run if nothing moves on any port for too long.
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog expired with %0d beats outstanding", $time, sb.pending());
            $display("FAILURE");
            $finish;
        end
    end

    // Consumer: random stalls, or one long hold-off on request.
    initial begin : consumer
        forever begin
            if (hold_go) begin
                hold_go = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
                @(posedge clk);
            end
        end
    end

    // Offer one tick beat, after a random gap, and wait for it to be taken.
    task automatic send_tick(input logic [epi_pkg::DT_W-1:0] dt, input logic restart);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.delta_time <= dt;
        in_ch.restart    <= restart;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Wait so the last accepted tick is noted, then until every beat is back, then let the block settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Let the block drain, then write the selected registers from the image.
    task automatic write_regs(input logic [7:0] sel);
        drain();
        for (int k = 0; k < 8; k++) begin
            if (sel[k]) begin
                cfg_we   <= 1'b1;
                cfg_idx  <= epi_pkg::CFG_IDX_W'(k);
                cfg_data <= cfg_image[k];
                @(posedge clk);
                sb.set_reg(epi_pkg::t_cfg_idx'(k), cfg_image[k]);
            end
        end
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    function automatic logic [epi_pkg::POS_W-1:0] pick_position();
        case ($urandom_range(7))
            0: return {1'b1, {(epi_pkg::POS_W-1){1'b0}}};
            1: return {1'b0, {(epi_pkg::POS_W-1){1'b1}}};
            2: return '0;
            3: return epi_pkg::POS_W'($urandom_range(0, 32'h0004_0000));
            4: return -epi_pkg::POS_W'($urandom_range(0, 32'h0004_0000));
            default: return epi_pkg::POS_W'($urandom());
        endcase
    endfunction

    // Durations lean small so moves complete within a phase; junk rides in the top byte.
    function automatic logic [epi_pkg::POS_W-1:0] pick_duration();
        logic [epi_pkg::POS_W-1:0] junk;
        logic [epi_pkg::POS_W-1:0] tmask;
        tmask = epi_pkg::POS_W'({epi_pkg::TIME_W{1'b1}});
        junk  = $urandom() & ~tmask;
        case ($urandom_range(9))
            0: return junk | epi_pkg::POS_W'(1);
            1: return junk | tmask;
            2: return junk;
            3, 4: return junk | epi_pkg::POS_W'($urandom_range(2, 64));
            5, 6, 7: return junk | epi_pkg::POS_W'($urandom_range(65, 200000));
            default: return junk | ($urandom() & tmask);
        endcase
    endfunction

    initial begin : stimulus
        int                        plan;
        int                        count;
        longint                    span;
        logic [epi_pkg::DT_W-1:0]  dt;
        logic                      restart;

        sb = new();
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= '0;
        cfg_data         <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.delta_time <= '0;
        in_ch.restart    <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero duration out of reset: the goal, still at its reset value, comes back.
        send_tick('0, 1'b0);
        send_tick('1, 1'b1);

        // Opposite full-scale spans on x and y, a small one on z, linear easing.
        cfg_image[epi_pkg::CFG_START_X]  = 32'h8000_0000;
        cfg_image[epi_pkg::CFG_START_Y]  = 32'h7fff_ffff;
        cfg_image[epi_pkg::CFG_START_Z]  = 32'h0001_0000;
        cfg_image[epi_pkg::CFG_GOAL_X]   = 32'h7fff_ffff;
        cfg_image[epi_pkg::CFG_GOAL_Y]   = 32'h8000_0000;
        cfg_image[epi_pkg::CFG_GOAL_Z]   = 32'hffff_0000;
        cfg_image[epi_pkg::CFG_DURATION] = 32'hff00_03e8;
        cfg_image[epi_pkg::CFG_EASING]   = 32'hffff_fffc | epi_pkg::POS_W'(epi_pkg::EASE_LINEAR);
        write_regs(ALL_REGS);
        send_tick('0, 1'b1);
        send_tick(16'd1, 1'b0);
        send_tick(16'd333, 1'b0);
        send_tick('1, 1'b0);
        send_tick(16'd500, 1'b1);

        // Full-scale duration with smoothstep, alternating bit patterns in the increment.
        cfg_image[epi_pkg::CFG_DURATION] = 32'h00ff_ffff;
        cfg_image[epi_pkg::CFG_EASING]   = 32'hffff_fffc | epi_pkg::POS_W'(epi_pkg::EASE_SMOOTH);
        write_regs(ALL_REGS);
        send_tick('1, 1'b1);
        send_tick('1, 1'b0);
        send_tick(16'haaaa, 1'b0);
        send_tick(16'h5555, 1'b0);

        // Ease-out over a three-unit move, stepped one unit at a time past the end.
        cfg_image[epi_pkg::CFG_DURATION] = 32'd3;
        cfg_image[epi_pkg::CFG_EASING]   = epi_pkg::POS_W'(epi_pkg::EASE_OUT_QUAD);
        write_regs(ALL_REGS);
        repeat (4) send_tick(16'd1, 1'b0);

        // The spare easing code on a one-unit move.
        cfg_image[epi_pkg::CFG_DURATION] = 32'd1;
        cfg_image[epi_pkg::CFG_EASING]   = epi_pkg::POS_W'(epi_pkg::EASE_LINEAR_ALT);
        write_regs(ALL_REGS);
        send_tick('0, 1'b1);
        send_tick(16'd1, 1'b0);

        // Shrinking the duration under the elapsed time saturates on the next tick.
        cfg_image[epi_pkg::CFG_DURATION] = 32'd10000;
        cfg_image[epi_pkg::CFG_EASING]   = epi_pkg::POS_W'(epi_pkg::EASE_SMOOTH);
        write_regs(ALL_REGS);
        send_tick(16'd8000, 1'b1);
        cfg_image[epi_pkg::CFG_DURATION] = 32'd100;
        write_regs(DUR_REG);
        send_tick('0, 1'b0);

        // Zero duration leaves elapsed time alone, though a restart still clears it.
        cfg_image[epi_pkg::CFG_DURATION] = 32'd0;
        write_regs(DUR_REG);
        send_tick(16'd7, 1'b0);
        send_tick(16'd123, 1'b1);
        cfg_image[epi_pkg::CFG_DURATION] = 32'd50;
        write_regs(DUR_REG);
        send_tick('0, 1'b0);

        // Random settings; each phase is mostly complete moves, with some noise mixed in.
        for (int p = 0; p < RAND_PHASES; p++) begin
            for (int k = epi_pkg::CFG_START_X; k <= epi_pkg::CFG_GOAL_Z; k++)
                cfg_image[k] = pick_position();
            cfg_image[epi_pkg::CFG_DURATION] = pick_duration();
            cfg_image[epi_pkg::CFG_EASING]   =
                ($urandom() & ~epi_pkg::POS_W'({epi_pkg::MODE_W{1'b1}}))
                | epi_pkg::POS_W'(MODE_CYCLE[(p + p / 4) % 4]);
            write_regs(ALL_REGS);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            // Early on, hold the output off while ticks keep coming, to back the block up.
            if (p == 4)
                hold_go = 1'b1;
            plan  = $urandom_range(2, 40);
            count = 0;
            for (int i = 0; i < PHASE_TICKS; i++) begin
                if ($urandom_range(99) < 12) begin
                    dt      = epi_pkg::DT_W'($urandom());
                    restart = 1'($urandom_range(1));
                end else begin
                    restart = (i == 0) || (count > plan);
                    if (restart) begin
                        count = 0;
                        plan  = $urandom_range(2, 40);
                    end
                    span = longint'(cfg_image[epi_pkg::CFG_DURATION][epi_pkg::TIME_W-1:0]) / plan;
                    span = span * $urandom_range(60, 140) / 100;
                    dt   = (span > longint'({epi_pkg::DT_W{1'b1}})) ? '1 : epi_pkg::DT_W'(span);
                    count++;
                end
                send_tick(dt, restart);
            end
        end

        // Wait for the last position beats, then give the block time to show any extras.
        drain();

        $display("Sent %0d ticks over %0d register loads, covering every easing code,",
                 sb.ticks_noted, settings_loaded);
        $display("zero, unit, full-scale and shrunk durations, four pacing mixes, one long stall");
        if (sb.pending() != 0)
            $display("%0d expected position beats never arrived", sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/epi_pkg.sv
rtl/epi_if.sv
rtl/eased_position_interpolator.sv
verif/eased_position_interpolator_test.sv
